FILE: rtl/odometry_gate_and_smoother_unit_defines.svh
// Assertion macros used by the odometry gate and smoother top level.
`ifndef ODOMETRY_GATE_AND_SMOOTHER_UNIT_DEFINES_SVH
`define ODOMETRY_GATE_AND_SMOOTHER_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define OGS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define OGS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/ogs_pkg.sv
// Shared types and constants for the odometry gate and smoother.
package ogs_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } ogs_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic [15:0]        est_yaw;
    logic signed [15:0] est_quat_z;
    logic signed [15:0] est_quat_w;
  } ogs_out_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_JUMP = 2'd2;

  localparam logic REG_WEIGHT = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  localparam int TabLen = 24;
  localparam logic signed [35:0] CordicGainQ30 = 36'sd652032874;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_tab(input logic [4:0] i);
    case (i)
      5'd0: atan_tab = 32'd536870912;
      5'd1: atan_tab = 32'd316933406;
      5'd2: atan_tab = 32'd167458907;
      5'd3: atan_tab = 32'd85004756;
      5'd4: atan_tab = 32'd42667331;
      5'd5: atan_tab = 32'd21354465;
      5'd6: atan_tab = 32'd10679838;
      5'd7: atan_tab = 32'd5340245;
      5'd8: atan_tab = 32'd2670163;
      5'd9: atan_tab = 32'd1335087;
      5'd10: atan_tab = 32'd667544;
      5'd11: atan_tab = 32'd333772;
      5'd12: atan_tab = 32'd166886;
      5'd13: atan_tab = 32'd83443;
      5'd14: atan_tab = 32'd41722;
      5'd15: atan_tab = 32'd20861;
      5'd16: atan_tab = 32'd10430;
      5'd17: atan_tab = 32'd5215;
      5'd18: atan_tab = 32'd2608;
      5'd19: atan_tab = 32'd1304;
      5'd20: atan_tab = 32'd652;
      5'd21: atan_tab = 32'd326;
      5'd22: atan_tab = 32'd163;
      5'd23: atan_tab = 32'd81;
      default: atan_tab = 32'd0;
    endcase
  endfunction

  // Shared CORDIC control from the sequencer.
  typedef struct packed {
    logic       load;
    logic       vect;
    logic [4:0] step;
  } ogs_cordic_ctl_t;

endpackage

FILE: rtl/odometry_gate_and_smoother_unit.sv
// Top level: sequencer, shared multiplier and CORDIC for the odometry smoother.
// The two CORDIC passes and the shared 33x33 multiplier set the time from request accept to
// result valid; a rejected sample skips the vectoring pass and the estimate update.
// Reset: asynchronous active low; clears the estimate, registers to their defaults.
// Output register holds the result until taken; the next input waits for it.
`include "odometry_gate_and_smoother_unit_defines.svh"
module odometry_gate_and_smoother_unit #(
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ogs_pkg::ogs_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ogs_pkg::ogs_out_t out_data_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [30:0]      cfg_data_i
);
  import ogs_pkg::*;

  localparam int ZW = ANGLE_BITS + 2;
  localparam int NS = (CORDIC_STEPS < TabLen) ? CORDIC_STEPS : TabLen;
  localparam logic [4:0] LastStep = 5'(NS - 1);
  localparam logic [4:0] DoneStep = 5'(NS);

  typedef enum logic [4:0] {
    S_IDLE, S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_P0, S_P1, S_DX, S_DY, S_LIM, S_GATE,
    S_VEC0, S_VEC, S_BX, S_BY, S_BZ, S_UPD, S_ROT0, S_RLD, S_ROT, S_OUT
  } state_e;

  state_e st_q;
  logic [16:0] weight_q;
  logic [30:0] limit_q;
  logic have_q;
  logic signed [31:0] hx_q, hy_q;
  logic [ANGLE_BITS-1:0] hyaw_q, raw_q;
  ogs_in_t in_q;
  logic [1:0] status_q;
  logic [4:0] step_q;
  logic signed [35:0] cx_q, cy_q;
  logic signed [ZW-1:0] cz_q;
  logic signed [66:0] acc_q;
  logic signed [65:0] prod_q;
  logic signed [32:0] ax_q, ay_q, dx_q, dy_q;
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic out_valid_q;
  ogs_out_t out_q;

  logic signed [35:0] cx_o, cy_o;
  logic signed [ZW-1:0] cz_o;
  ogs_cordic_ctl_t ctl;

  // Held yaw as the signed start angle of the rotation
  logic signed [ZW-1:0] zinit;
  assign zinit = ZW'(signed'(hyaw_q));

  // One shared signed multiplier, operands chosen by state
  always_comb begin
    ma = '0; mb = '0;
    case (st_q)
      S_SQ0: begin ma = 33'(in_q.quat_x); mb = 33'(in_q.quat_x); end
      S_SQ1: begin ma = 33'(in_q.quat_y); mb = 33'(in_q.quat_y); end
      S_SQ2: begin ma = 33'(in_q.quat_z); mb = 33'(in_q.quat_z); end
      S_SQ3: begin ma = 33'(in_q.quat_w); mb = 33'(in_q.quat_w); end
      S_P0:  begin ma = 33'(in_q.quat_w); mb = 33'(in_q.quat_z); end
      S_P1:  begin ma = 33'(in_q.quat_x); mb = 33'(in_q.quat_y); end
      S_DX:  begin ma = ax_q; mb = ax_q; end
      S_DY:  begin ma = ay_q; mb = ay_q; end
      S_LIM: begin ma = {2'b0, limit_q}; mb = {2'b0, limit_q}; end
      S_BX:  begin ma = dx_q; mb = {16'b0, weight_q}; end
      S_BY:  begin ma = dy_q; mb = {16'b0, weight_q}; end
      S_BZ:  begin ma = 33'(signed'(raw_q - hyaw_q)); mb = {16'b0, weight_q}; end
      default: ;
    endcase
    prod = ma * mb;
  end

  always_comb begin
    ctl.load = (st_q == S_VEC0) || (st_q == S_RLD);
    ctl.vect = (st_q == S_VEC0) || (st_q == S_VEC);
    ctl.step = step_q;
  end

  ogs_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk_i(clk_i), .ctl_i(ctl), .x0_i(cx_q), .y0_i(cy_q), .z0_i(cz_q),
    .x_o(cx_o), .y_o(cy_o), .z_o(cz_o)
  );

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    if (v > 67'sd2147483647) sat32 = 32'h7fffffff;
    else if (v < -67'sd2147483648) sat32 = 32'h80000000;
    else sat32 = v[31:0];
  endfunction

  function automatic logic signed [15:0] clampq(input logic signed [35:0] v);
    logic signed [35:0] r;
    r = (v + 36'sd32768) >>> 16;
    if (r > 36'sd16384) clampq = 16'sd16384;
    else if (r < -36'sd16384) clampq = -16'sd16384;
    else clampq = r[15:0];
  endfunction

  logic signed [32:0] dxn, dyn;
  assign dxn = 33'(in_q.pos_x) - 33'(hx_q);
  assign dyn = 33'(in_q.pos_y) - 33'(hy_q);

  assign in_ready_o  = (st_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sequencer and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; weight_q <= 17'd22938; limit_q <= 31'd65536;
      have_q <= 1'b0; hx_q <= '0; hy_q <= '0; hyaw_q <= '0;
      out_valid_q <= 1'b0; step_q <= '0; status_q <= ST_OK;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_WEIGHT) weight_q <= cfg_data_i[16:0];
        else limit_q <= cfg_data_i;
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      prod_q <= prod;
      case (st_q)
        S_IDLE: if (in_valid_i && in_ready_o) begin
          in_q <= in_data_i; st_q <= S_SQ0; acc_q <= '0; status_q <= ST_OK;
        end
        S_SQ0: st_q <= S_SQ1;
        S_SQ1: begin acc_q <= 67'(prod_q); st_q <= S_SQ2; end         // x^2
        S_SQ2: begin acc_q <= acc_q - 67'(prod_q); st_q <= S_SQ3; end // -y^2
        S_SQ3: begin acc_q <= acc_q - 67'(prod_q); st_q <= S_P0; end  // -z^2
        S_P0: begin
          cx_q <= 36'(acc_q + 67'(prod_q)); st_q <= S_P1;             // +w^2
          ax_q <= dxn < 0 ? -dxn : dxn; ay_q <= dyn < 0 ? -dyn : dyn;
          dx_q <= dxn; dy_q <= dyn;
        end
        S_P1: begin acc_q <= 67'(prod_q); st_q <= S_DX; end
        S_DX: begin cy_q <= 36'((acc_q + 67'(prod_q)) <<< 1); acc_q <= '0; st_q <= S_DY; end
        S_DY: begin acc_q <= 67'(prod_q); st_q <= S_LIM; end
        S_LIM: begin acc_q <= acc_q + 67'(prod_q); st_q <= S_GATE; end
        S_GATE: begin
          if (in_q.quat_x == 0 && in_q.quat_y == 0 && in_q.quat_z == 0 &&
              in_q.quat_w == 0) begin
            status_q <= ST_ZERO; st_q <= S_ROT0;
          end else if (have_q && (ax_q > 33'({2'b0, limit_q}) ||
                       ay_q > 33'({2'b0, limit_q}) || acc_q > 67'(prod_q))) begin
            status_q <= ST_JUMP; st_q <= S_ROT0;
          end else if (cx_q == 0 && cy_q == 0) begin
            raw_q <= '0; st_q <= S_BX;
          end else begin
            st_q <= S_VEC0;
            if (cx_q < 0) begin
              cx_q <= -cx_q; cy_q <= -cy_q;
              cz_q <= ZW'(signed'({1'b0, 1'b1, {(ANGLE_BITS-1){1'b0}}}));
            end else begin
              cz_q <= '0;
            end
          end
          step_q <= '0;
        end
        S_VEC0: st_q <= S_VEC;
        S_VEC: begin
          step_q <= step_q + 5'd1;
          if (step_q == LastStep) begin
            st_q <= S_BX;
          end
        end
        S_BX: begin
          if (step_q == DoneStep) raw_q <= cz_o[ANGLE_BITS-1:0];
          step_q <= '0; st_q <= S_BY;
        end
        S_BY: begin
          hx_q <= have_q ? sat32(67'(hx_q) + ((67'(prod_q) + 67'sd32768) >>> 16))
                         : in_q.pos_x;
          st_q <= S_BZ;
        end
        S_BZ: begin
          hy_q <= have_q ? sat32(67'(hy_q) + ((67'(prod_q) + 67'sd32768) >>> 16))
                         : in_q.pos_y;
          st_q <= S_UPD;
        end
        S_UPD: begin
          if (status_q == ST_OK) begin
            hyaw_q <= have_q ? ANGLE_BITS'(67'(hyaw_q) +
                      ((67'(prod_q) + 67'sd32768) >>> 16)) : raw_q;
            have_q <= 1'b1;
          end
          st_q <= S_ROT0;
        end
        // set up the rotation from the held yaw
        S_ROT0: begin
          st_q <= S_RLD; step_q <= '0;
          cx_q <= CordicGainQ30; cy_q <= '0; cz_q <= zinit;
        end
        S_RLD: st_q <= S_ROT;
        S_ROT: begin
          step_q <= step_q + 5'd1;
          if (step_q == LastStep) st_q <= S_OUT;
        end
        S_OUT: begin
          out_q.status <= status_q; out_q.est_x <= hx_q; out_q.est_y <= hy_q;
          if (ANGLE_BITS >= 16) out_q.est_yaw <= 16'(hyaw_q >> (ANGLE_BITS - 16));
          else out_q.est_yaw <= 16'({hyaw_q, 16'b0} >> ANGLE_BITS);
          out_q.est_quat_z <= clampq(cy_o); out_q.est_quat_w <= clampq(cx_o);
          out_valid_q <= 1'b1; st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  `OGS_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, in_ready_o, st_q == S_IDLE)
  `OGS_ASSERT_NXT(a_out_from_seq, clk_i, rst_ni, st_q == S_OUT, out_valid_o)
  `OGS_ASSERT_IMP(a_no_in_busy, clk_i, rst_ni, out_valid_o, !in_ready_o)
endmodule

FILE: rtl/ogs_cordic.sv
// Shared iterative CORDIC: vectoring for atan2, rotation for half sin/cos.
module ogs_cordic #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk_i,
  input  ogs_pkg::ogs_cordic_ctl_t ctl_i,
  input  logic signed [35:0]    x0_i,
  input  logic signed [35:0]    y0_i,
  input  logic signed [ANGLE_BITS+1:0] z0_i,
  output logic signed [35:0]    x_o,
  output logic signed [35:0]    y_o,
  output logic signed [ANGLE_BITS+1:0] z_o
);
  import ogs_pkg::*;

  localparam int ZW = ANGLE_BITS + 2;

  logic signed [35:0] x_q, y_q, x_d, y_d, xs, ys;
  logic signed [ZW-1:0] z_q, z_d, a;
  logic [32:0] rnd;
  logic [4:0] sh;
  logic up;

  // Angle step rounded half up to the working unit
  always_comb begin
    sh  = ctl_i.vect ? 5'(32 - ANGLE_BITS) : 5'(31 - ANGLE_BITS);
    rnd = ({1'b0, atan_tab(ctl_i.step)} + (33'd1 << (sh - 5'd1))) >> sh;
    a   = ZW'(signed'({1'b0, rnd}));
    xs  = x_q >>> ctl_i.step;
    ys  = y_q >>> ctl_i.step;
    up  = ctl_i.vect ? (y_q > 0) : (z_q >= 0);
    if (ctl_i.vect ? up : up) begin
      if (ctl_i.vect) begin
        x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + a;
      end else begin
        x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - a;
      end
    end else begin
      if (ctl_i.vect) begin
        x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - a;
      end else begin
        x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + a;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      x_q <= x0_i; y_q <= y0_i; z_q <= z0_i;
    end else begin
      x_q <= x_d; y_q <= y_d; z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule
